>>> rtl/ikhm_pkg.sv
`timescale 1ns / 1ps
package ikhm_pkg;
  localparam logic [63:0] MIX_MUL_A = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_MUL_B = 64'h94d049bb133111eb;
  localparam int MIX_SHIFT_A = 30;
  localparam int MIX_SHIFT_B = 27;
  localparam int MIX_SHIFT_C = 31;

  localparam logic CMD_PUT = 1'b0;
  localparam logic CMD_GET = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MIX1, S_MIX2, S_MIX3, S_MIX4, S_MIX5,
    S_READ, S_CHECK, S_OUT
  } ikhm_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic clr_step;    // clear one occupancy row and advance
    logic load;        // capture the input beat
    logic mix_step;    // advance the hash pipeline by one step
    logic rd_issue;    // issue a table read at the probe slot
    logic probe_next;  // advance probe slot
    logic finish;      // commit the result and update store and cache
    logic out_pop;     // result beat taken
  } ikhm_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic clr_done;
    logic cache_hit;   // get answered by the cache
    logic slot_free;   // probed slot is empty
    logic key_match;   // probed slot holds the key
    logic wrapped;     // probe visited every slot
  } ikhm_stat_t;
endpackage

>>> rtl/ikhm_if.sv
`timescale 1ns / 1ps
interface ikhm_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [63:0] key;
  logic [63:0] value;
  modport source (output valid, command, key, value, input ready);
  modport sink (input valid, command, key, value, output ready);
endinterface

interface ikhm_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] read_value;
  logic [1:0]  status;
  modport source (output valid, read_value, status, input ready);
  modport sink (input valid, read_value, status, output ready);
endinterface

>>> rtl/ikhm_datapath.sv
`timescale 1ns / 1ps
module ikhm_datapath
  import ikhm_pkg::*;
#(
  parameter int TABLE_SIZE = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  ikhm_cmd_t   cmd,
  output ikhm_stat_t  stat,
  input  logic        in_command,
  input  logic [63:0] in_key,
  input  logic [63:0] in_value,
  output logic        out_valid,
  output logic [63:0] out_read_value,
  output logic [1:0]  out_status
);
  localparam int IW = $clog2(TABLE_SIZE);
  localparam int CW = IW + 1;
  localparam logic [CW-1:0] HALF = CW'(TABLE_SIZE / 2);

  logic          used_mem [TABLE_SIZE];
  logic [63:0]   key_mem  [TABLE_SIZE];
  logic [63:0]   val_mem  [TABLE_SIZE];

  logic [IW-1:0] clr_idx_r;
  logic          clr_done_r;
  logic          cmd_r;
  logic [63:0]   key_r, val_r, mix_r;
  logic [2:0]    mix_cnt_r;
  logic [IW-1:0] pos_r;
  logic [CW-1:0] probes_r;
  logic          used_q;
  logic [63:0]   key_q, val_q;
  logic [CW-1:0] count_r;
  logic [63:0]   rkey_r, rval_r;
  logic          rfound_r;
  logic          ov_r;
  logic [63:0]   orv_r;
  logic [1:0]    ost_r;
  logic [31:0]   mlo_r, mhi_r;

  assign stat.clr_done  = clr_done_r;
  assign stat.cache_hit = (cmd_r == CMD_GET) && (count_r != '0) && (key_r == rkey_r);
  assign stat.slot_free = !used_q;
  assign stat.key_match = used_q && (key_q == key_r);
  assign stat.wrapped   = probes_r == CW'(TABLE_SIZE);
  assign out_valid      = ov_r;
  assign out_read_value = orv_r;
  assign out_status     = ost_r;

  // Occupancy bits, cleared by a sweep after reset.
  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      used_mem[clr_idx_r] <= 1'b0;
    end else if (cmd.finish && cmd_r == CMD_PUT && !stat.key_match && stat.slot_free &&
                 !stat.wrapped && count_r <= HALF) begin
      used_mem[pos_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && cmd_r == CMD_PUT && (stat.key_match ||
        (stat.slot_free && !stat.wrapped && count_r <= HALF))) begin
      key_mem[pos_r] <= key_r;
      val_mem[pos_r] <= val_r;
    end
    if (cmd.rd_issue) begin
      used_q <= used_mem[pos_r];
      key_q  <= key_mem[pos_r];
      val_q  <= val_mem[pos_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r  <= '0;
      clr_done_r <= 1'b0;
    end else if (cmd.clr_step) begin
      clr_idx_r <= clr_idx_r + 1'b1;
      if (clr_idx_r == IW'(TABLE_SIZE - 1)) clr_done_r <= 1'b1;
    end
  end

  // Hash: five steps, each at most one 32x32 partial product set.
  // Step 1: xor shift A. Step 2/3: multiply A in halves. Step 4/5 likewise
  // with B; the final xor shift C is folded when the home slot is taken.
  logic [63:0] mix_nxt;
  logic [63:0] mul_k;
  always_comb begin
    mix_nxt = mix_r;
    mul_k   = (mix_cnt_r < 3'd3) ? MIX_MUL_A : MIX_MUL_B;
    case (mix_cnt_r)
      3'd0: mix_nxt = key_r ^ (key_r >> MIX_SHIFT_A);
      3'd1, 3'd3: mix_nxt = mix_r;
      3'd2, 3'd4: mix_nxt = {mhi_r + mlo_r, 32'd0} + 64'(mix_r[31:0]) * 64'(mul_k[31:0]);
      default: mix_nxt = mix_r;
    endcase
    if (mix_cnt_r == 3'd3) mix_nxt = mix_nxt ^ (mix_nxt >> MIX_SHIFT_B);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r     <= in_command;
      key_r     <= in_key;
      val_r     <= in_value;
      mix_cnt_r <= '0;
    end else if (cmd.mix_step) begin
      if (mix_cnt_r == 3'd3) begin
        mix_r <= mix_r ^ (mix_r >> MIX_SHIFT_B);
        mlo_r <= mix_nxt[31:0] * mul_k[63:32];
        mhi_r <= mix_nxt[63:32] * mul_k[31:0];
      end else if (mix_cnt_r == 3'd1) begin
        mlo_r <= mix_r[31:0] * mul_k[63:32];
        mhi_r <= mix_r[63:32] * mul_k[31:0];
      end else begin
        mix_r <= mix_nxt;
      end
      mix_cnt_r <= mix_cnt_r + 3'd1;
    end
  end

  // Only the low index bits of the final xor shift are needed.
  logic [IW-1:0] home_slot;
  assign home_slot = mix_nxt[IW-1:0] ^ mix_nxt[MIX_SHIFT_C +: IW];

  always_ff @(posedge clk) begin
    if (cmd.mix_step && mix_cnt_r == 3'd4) begin
      pos_r    <= home_slot;
      probes_r <= '0;
    end else if (cmd.probe_next) begin
      pos_r    <= pos_r + 1'b1;
      probes_r <= probes_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      rkey_r   <= '0;
      rval_r   <= '0;
      rfound_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      if (cmd.out_pop) ov_r <= 1'b0;
      if (cmd.finish) begin
        ov_r <= 1'b1;
        if (cmd_r == CMD_PUT) begin
          orv_r <= '0;
          if (stat.key_match || (stat.slot_free && !stat.wrapped && count_r <= HALF)) begin
            ost_r    <= ST_OK;
            rkey_r   <= key_r;
            rval_r   <= val_r;
            rfound_r <= 1'b1;
            if (!stat.key_match) count_r <= count_r + 1'b1;
          end else begin
            ost_r <= ST_FULL;
          end
        end else if (stat.cache_hit) begin
          orv_r <= rfound_r ? rval_r : '0;
          ost_r <= rfound_r ? ST_OK : ST_NOTFOUND;
        end else begin
          rkey_r   <= key_r;
          rfound_r <= stat.key_match;
          rval_r   <= stat.key_match ? val_q : '0;
          orv_r    <= stat.key_match ? val_q : '0;
          ost_r    <= stat.key_match ? ST_OK : ST_NOTFOUND;
        end
      end
    end
  end
endmodule

>>> rtl/ikhm_ctrl.sv
`timescale 1ns / 1ps
module ikhm_ctrl
  import ikhm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       out_valid,
  input  logic       out_ready,
  input  ikhm_stat_t stat,
  output ikhm_cmd_t  cmd
);
  ikhm_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLEAR;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (stat.clr_done) state_nxt = S_IDLE;
      S_IDLE:  if (in_valid && (!out_valid || out_ready)) state_nxt = S_MIX1;
      S_MIX1:  state_nxt = stat.cache_hit ? S_OUT : S_MIX2;
      S_MIX2:  state_nxt = S_MIX3;
      S_MIX3:  state_nxt = S_MIX4;
      S_MIX4:  state_nxt = S_MIX5;
      S_MIX5:  state_nxt = S_READ;
      S_READ:  state_nxt = S_CHECK;
      S_CHECK: if (stat.slot_free || stat.key_match || stat.wrapped) state_nxt = S_OUT;
               else state_nxt = S_READ;
      S_OUT:   state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    cmd.out_pop = out_valid && out_ready;
    case (state_r)
      S_CLEAR: cmd.clr_step = !stat.clr_done;
      S_IDLE: begin
        in_ready = !out_valid || out_ready;
        cmd.load = in_valid && in_ready;
      end
      S_MIX1, S_MIX2, S_MIX3, S_MIX4: cmd.mix_step = !(state_r == S_MIX1 && stat.cache_hit);
      S_MIX5:  cmd.mix_step = 1'b1;
      S_READ:  cmd.rd_issue = 1'b1;
      S_CHECK: cmd.probe_next = !(stat.slot_free || stat.key_match || stat.wrapped);
      S_OUT:   cmd.finish = 1'b1;
      default: cmd = '0;
    endcase
  end
endmodule

>>> rtl/integer_key_hash_map_top.sv
`timescale 1ns / 1ps
// Channel   Direction  Beat contents
// in        sink       command, key, value
// out       source     read_value, status
//
// A get answered by the last-key cache skips the hash steps and the table read;
// other items pass through the hash steps and one table read per probe.
// After reset a clearing pass over all TABLE_SIZE slots zeroes the occupancy
// bits; no beat is accepted meanwhile. Reset is synchronous, active low.
// A result waits in the output register; the next beat is taken with it.
module integer_key_hash_map_top
  import ikhm_pkg::*;
#(
  parameter int TABLE_SIZE = 1024
) (
  input logic clk,
  input logic rst_n,
  ikhm_in_if.sink    in_ch,
  ikhm_out_if.source out_ch
);
  ikhm_cmd_t  cmd;
  ikhm_stat_t stat;

  // The controller sequences hashing, probing and the result handoff.
  ikhm_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .stat, .cmd
  );

  // The datapath holds the table, the cache and the result register.
  ikhm_datapath #(.TABLE_SIZE(TABLE_SIZE)) u_dp (
    .clk, .rst_n, .cmd, .stat,
    .in_command(in_ch.command), .in_key(in_ch.key), .in_value(in_ch.value),
    .out_valid(out_ch.valid), .out_read_value(out_ch.read_value),
    .out_status(out_ch.status)
  );
endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import ikhm_pkg::*;

  localparam int SLOTS = 1024;
  localparam int CYCLE_LIMIT = 4000000;

  // Expected result of one beat on the output channel.
  typedef struct {
    logic [63:0] read_value;
    logic [1:0]  status;
  } map_answer_t;

  logic clk;
  logic rst_n;

  ikhm_in_if  in_ch ();
  ikhm_out_if out_ch ();

  integer_key_hash_map_top #(.TABLE_SIZE(SLOTS)) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  // Shadow copy of the map, kept in step with every accepted input beat.
  bit          shadow_used [SLOTS];
  logic [63:0] shadow_key  [SLOTS];
  logic [63:0] shadow_value[SLOTS];
  int          shadow_count;
  logic [63:0] cache_key;
  logic [63:0] cache_value;
  bit          cache_found;

  map_answer_t pending_answers[$];
  logic [63:0] stored_keys[$];   // keys that were placed, reused by the stimulus
  int          error_count;
  longint      cycle_count;
  bit          idle_enable;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Splitmix64 finalizer, masked down to a slot index.
  function automatic int home_of(logic [63:0] k);
    k = (k ^ (k >> MIX_SHIFT_A)) * MIX_MUL_A;
    k = (k ^ (k >> MIX_SHIFT_B)) * MIX_MUL_B;
    k = k ^ (k >> MIX_SHIFT_C);
    return int'(k[9:0]);
  endfunction

  // Walk the probe path. Returns 1 with slot at the key when present,
  // otherwise 0 with slot at the first free entry (has_free tells if any).
  function automatic bit find_slot(logic [63:0] k, output int slot, output bit has_free);
    int s;
    s = home_of(k);
    has_free = 1'b0;
    slot = s;
    for (int n = 0; n < SLOTS; n++) begin
      if (!shadow_used[s]) begin
        slot = s;
        has_free = 1'b1;
        return 1'b0;
      end
      if (shadow_key[s] == k) begin
        slot = s;
        return 1'b1;
      end
      s = (s + 1) % SLOTS;
    end
    return 1'b0;
  endfunction

  // Apply one command to the shadow map and return what the block must answer.
  function automatic map_answer_t apply_command(logic cmd, logic [63:0] k, logic [63:0] v);
    map_answer_t ans;
    int slot;
    bit has_free;
    bit hit;
    ans.read_value = '0;
    ans.status = ST_OK;
    if (cmd == CMD_PUT) begin
      hit = find_slot(k, slot, has_free);
      if (hit) begin
        shadow_value[slot] = v;
      end else if (shadow_count > SLOTS / 2 || !has_free) begin
        // Refused insert: nothing stored and the cache stays as it was.
        ans.status = ST_FULL;
        return ans;
      end else begin
        shadow_used[slot] = 1'b1;
        shadow_key[slot] = k;
        shadow_value[slot] = v;
        shadow_count++;
        stored_keys.push_back(k);
      end
      cache_key = k;
      cache_value = v;
      cache_found = 1'b1;
      return ans;
    end
    // A get consults the cache only once the table holds something.
    if (shadow_count == 0 || k != cache_key) begin
      hit = find_slot(k, slot, has_free);
      cache_key = k;
      cache_found = hit;
      cache_value = hit ? shadow_value[slot] : '0;
    end
    ans.read_value = cache_found ? cache_value : '0;
    ans.status = cache_found ? ST_OK : ST_NOTFOUND;
    return ans;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
    error_count++;
  endtask

  // Random idle burst, taken about a quarter of the time.
  task automatic maybe_idle();
    if (idle_enable && $urandom_range(3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(14, 1)) @(posedge clk);
    end
  endtask

  // Send one beat; the expected answer is queued at the edge that accepts it.
  // Valid stays high after the beat until an idle burst or a drain drops it.
  task automatic send_beat(logic cmd, logic [63:0] k, logic [63:0] v);
    maybe_idle();
    in_ch.valid   <= 1'b1;
    in_ch.command <= cmd;
    in_ch.key     <= k;
    in_ch.value   <= v;
    do @(posedge clk); while (!in_ch.ready);
    pending_answers.push_back(apply_command(cmd, k, v));
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  // Result side: random stalls on ready, checks each beat against the oldest
  // expectation. Its stalls are switched by idle_enable, like the sender's idles.
  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (idle_enable && $urandom_range(3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(14, 1)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        if (pending_answers.size() == 0) begin
          report_mismatch("unexpected beat", {62'd0, out_ch.status}, '0);
        end else begin
          map_answer_t want;
          want = pending_answers.pop_front();
          if (out_ch.read_value !== want.read_value)
            report_mismatch("read_value", out_ch.read_value, want.read_value);
          if (out_ch.status !== want.status)
            report_mismatch("status", {62'd0, out_ch.status}, {62'd0, want.status});
        end
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Edge values of key and value, gets on an empty table, the zero key that
  // matches the reset cache, repeated gets and an overwrite.
  task automatic test_directed();
    send_beat(CMD_GET, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_beat(CMD_GET, 64'd0, 64'd0);
    send_beat(CMD_GET, 64'hFFFF_FFFF_FFFF_FFFF, 64'd5);
    send_beat(CMD_PUT, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_beat(CMD_GET, 64'd0, 64'd0);
    send_beat(CMD_GET, 64'd0, 64'd7);
    send_beat(CMD_PUT, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
    send_beat(CMD_GET, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
    send_beat(CMD_PUT, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0001);
    send_beat(CMD_GET, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
    send_beat(CMD_GET, 64'h1234_5678_9ABC_DEF0, 64'd0);
    send_beat(CMD_GET, 64'h1234_5678_9ABC_DEF0, 64'd0);
    send_beat(CMD_GET, 64'd0, 64'd0);
    send_beat(CMD_PUT, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
    send_beat(CMD_PUT, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
    send_beat(CMD_GET, 64'h5555_5555_5555_5555, 64'd0);
    send_beat(CMD_GET, 64'hAAAA_AAAA_AAAA_AAAA, 64'd0);
    // Sender holds off until every answer is back.
    wait_drained();
  endtask

  // Mixed traffic: mostly known keys, with new keys and misses between.
  task automatic test_random_mix(int beats);
    logic [63:0] k;
    for (int i = 0; i < beats; i++) begin
      if (stored_keys.size() != 0 && $urandom_range(9) < 6)
        k = stored_keys[$urandom_range(stored_keys.size() - 1)];
      else if ($urandom_range(9) == 0)
        k = cache_key;
      else
        k = rand64();
      send_beat($urandom_range(1) ? CMD_GET : CMD_PUT, k, rand64());
    end
  endtask

  // Fill past half load so inserts are refused, then check overwrites and
  // lookups still behave on a crowded table with long probe runs.
  task automatic test_table_full();
    while (shadow_count <= SLOTS / 2)
      send_beat(CMD_PUT, rand64(), rand64());
    for (int i = 0; i < 6; i++)
      send_beat(CMD_PUT, rand64(), rand64());
    send_beat(CMD_PUT, stored_keys[0], 64'hFFFF_FFFF_FFFF_FFFF);
    send_beat(CMD_GET, stored_keys[0], 64'd0);
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.command = CMD_PUT;
    in_ch.key = '0;
    in_ch.value = '0;
    error_count = 0;
    cycle_count = 0;
    idle_enable = 1'b1;
    cache_key = '0;
    cache_value = '0;
    cache_found = 1'b0;
    shadow_count = 0;
    foreach (shadow_used[i]) shadow_used[i] = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_mix(400);
    test_table_full();
    test_random_mix(300);
    // Final stretch at full rate on both sides.
    idle_enable = 1'b0;
    test_random_mix(150);

    wait_drained();
    repeat (40) @(posedge clk);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
